// File: hw/rtl/smmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics package
// Shared types and constants for the mean, median and quantile unit.
// ----------------------------------------------------------------------------
package smmq_pkg;

  localparam int MaxSamples = 256;
  localparam int SampleW    = 32;
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int IdxW       = $clog2(MaxSamples);
  localparam int SumW       = SampleW + IdxW;
  localparam int FracW      = 17;
  localparam int DivSteps   = SumW;
  localparam logic [FracW-1:0] FracOne   = FracW'(65536);
  localparam logic [FracW-1:0] FracReset = FracW'(62259);

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] mean_value;
    logic signed [31:0] median_value;
    logic signed [31:0] quantile_value;
    logic [8:0]         sample_count;
    logic               overflow_flag;
  } out_word_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StIdle,
    StPrep,
    StRun,
    StFin
  } state_e;

endpackage
`default_nettype wire

// File: hw/rtl/smmq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorter cell
// One slot of the insertion sorter; can also shift its value toward slot 0 or be cleared.
// ----------------------------------------------------------------------------
module smmq_cell import smmq_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cell_ctrl_t                ctrl_i,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire logic signed [SampleW-1:0] prev_value_i,
  input  wire logic                      prev_gt_i,
  input  wire logic                      prev_valid_i,
  input  wire logic signed [SampleW-1:0] next_value_i,
  output logic signed [SampleW-1:0]      value_o,
  output logic                           gt_o,
  output logic                           valid_o
);

  logic signed [SampleW-1:0] value_q, value_d;
  logic                      valid_q, valid_d;

  assign gt_o    = !valid_q || (value_q > sample_i);
  assign value_o = value_q;
  assign valid_o = valid_q;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
    end else if (ctrl_i.ins) begin
      valid_d = valid_q | prev_valid_i;
      if (gt_o) begin
        value_d = prev_gt_i ? prev_value_i : sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/smmq_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle while step_i is high.
// ----------------------------------------------------------------------------
module smmq_divider import smmq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              start_i,
  input  wire logic              step_i,
  input  wire logic [SumW-1:0]   dividend_i,
  input  wire logic [CntW-1:0]   divisor_i,
  output logic [SumW-1:0]        quotient_o
);

  logic [SumW-1:0] quo_q, quo_d;
  logic [CntW:0]   rem_q, rem_d;
  logic [CntW:0]   trial;

  assign quotient_o = quo_q;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    trial = {rem_q[CntW-1:0], quo_q[SumW-1]};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/sample_mean_median_quantile_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample mean, median and quantile unit
// Sorts a set of samples as they arrive and reports its statistics.
//
// A sample word is taken at a clock edge where start_i is high and busy_o is
// low. Samples enter a row of sorter cells, one per cycle while busy_o is
// low, and a running sum is kept. A word with last_sample set closes the set.
// The unit then raises busy_o: a prep step forms the quantile position, the
// sorted row shifts out past slot 0 while a serial divider forms the mean,
// and a final step forms the median and quantile. The result word shows on
// result_o for one cycle with result_valid_o high; the receiver cannot stall
// it, and the unit takes new samples in that same cycle. Samples beyond the
// capacity are dropped and flagged. The user must write the quantile fraction
// through cfg_we_i and cfg_wdata_i only while the unit is idle; the block does
// not enforce this. Reset empties the sorter and sets the fraction to 0.95.
// ----------------------------------------------------------------------------
module sample_mean_median_quantile_unit import smmq_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire in_word_t         in_i,
  output out_word_t             result_o,
  output logic                  result_valid_o,
  input  wire logic             cfg_we_i,
  input  wire logic [FracW-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic [FracW-1:0]       frac_cfg_q;
  logic [CntW-1:0]        count_q;
  logic signed [SumW-1:0] sum_q;
  logic                   drop_q;
  logic [CntW+FracW-1:0]  hq_q;
  logic [IdxW-1:0]        idx_q;
  logic signed [SampleW-1:0] med_a_q, med_b_q, qa_q, qb_q;
  out_word_t              result_q;
  logic                   result_valid_q;

  logic                   accept;
  logic                   keep;
  cell_ctrl_t             ctrl;
  logic                   div_start, div_step;
  logic [SumW-1:0]        sum_abs, quo;
  logic [FracW-1:0]       frac_sat;

  logic signed [SampleW-1:0] cell_value [MaxSamples];
  logic                      cell_gt    [MaxSamples];
  logic                      cell_valid [MaxSamples];

  assign accept = start_i && !busy_o;
  assign keep   = count_q < CntW'(MaxSamples);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept && in_i.last_sample) state_d = StPrep;
      StPrep: state_d = StRun;
      StRun:  if (idx_q == IdxW'(MaxSamples - 1)) state_d = StFin;
      StFin:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    busy_o     = 1'b1;
    ctrl       = '0;
    div_start  = 1'b0;
    div_step   = 1'b0;
    case (state_q)
      StIdle: begin
        busy_o   = 1'b0;
        ctrl.ins = accept && keep;
      end
      StPrep: div_start = 1'b1;
      StRun: begin
        ctrl.shift = 1'b1;
        div_step   = idx_q < IdxW'(DivSteps);
      end
      StFin: ctrl.clr = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  for (genvar i = 0; i < MaxSamples; i++) begin : g_cell
    logic signed [SampleW-1:0] prev_v, next_v;
    logic                      prev_g, prev_ok;
    if (i == 0) begin : g_first
      assign prev_v  = '0;
      assign prev_g  = 1'b0;
      assign prev_ok = 1'b1;
    end else begin : g_mid
      assign prev_v  = cell_value[i-1];
      assign prev_g  = cell_gt[i-1];
      assign prev_ok = cell_valid[i-1];
    end
    if (i == MaxSamples - 1) begin : g_end
      assign next_v = '0;
    end else begin : g_nxt
      assign next_v = cell_value[i+1];
    end
    smmq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .sample_i     (in_i.sample_value),
      .prev_value_i (prev_v),
      .prev_gt_i    (prev_g),
      .prev_valid_i (prev_ok),
      .next_value_i (next_v),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i]),
      .valid_o      (cell_valid[i])
    );
  end

  assign sum_abs = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  smmq_divider u_div (
    .clk_i      (clk_i),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (sum_abs),
    .divisor_i  (count_q),
    .quotient_o (quo)
  );

  assign frac_sat = (frac_cfg_q > FracOne) ? FracOne : frac_cfg_q;

  logic [CntW-1:0]         med_b_idx, med_a_idx, lo_idx, hi_idx;
  logic signed [SampleW:0] med_sum;
  logic [SampleW:0]        diff;
  logic [SampleW+16:0]     prod;
  logic [SumW-1:0]         mean_full;

  assign med_b_idx = count_q >> 1;
  assign med_a_idx = med_b_idx - CntW'(1);
  assign lo_idx    = hq_q[CntW+15:16];
  assign hi_idx    = lo_idx + CntW'(1);
  assign med_sum   = (SampleW+1)'(med_a_q) + (SampleW+1)'(med_b_q);
  assign diff      = (SampleW+1)'(qb_q) - (SampleW+1)'(qa_q);
  assign prod      = (SampleW+17)'(hq_q[15:0]) * (SampleW+17)'(diff);
  assign mean_full = sum_q[SumW-1] ? SumW'(-quo) : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      frac_cfg_q     <= FracReset;
      count_q        <= '0;
      sum_q          <= '0;
      drop_q         <= 1'b0;
      idx_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= 1'b0;
      if (cfg_we_i) frac_cfg_q <= cfg_wdata_i;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (keep) begin
              count_q <= count_q + CntW'(1);
              sum_q   <= sum_q + SumW'(in_i.sample_value);
            end else begin
              drop_q <= 1'b1;
            end
          end
        end
        StPrep: idx_q <= '0;
        StRun:  idx_q <= idx_q + IdxW'(1);
        StFin: begin
          result_valid_q <= 1'b1;
          count_q        <= '0;
          sum_q          <= '0;
          drop_q         <= 1'b0;
        end
        default: idx_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StPrep) begin
      hq_q <= (CntW+FracW)'(count_q - CntW'(1)) * (CntW+FracW)'(frac_sat);
    end
    if (state_q == StRun) begin
      if (CntW'(idx_q) == med_a_idx) med_a_q <= cell_value[0];
      if (CntW'(idx_q) == med_b_idx) med_b_q <= cell_value[0];
      if (CntW'(idx_q) == lo_idx)    qa_q    <= cell_value[0];
      if (CntW'(idx_q) == hi_idx)    qb_q    <= cell_value[0];
    end
    if (state_q == StFin) begin
      result_q.mean_value     <= mean_full[SampleW-1:0];
      result_q.median_value   <= count_q[0] ? med_b_q : med_sum[SampleW:1];
      result_q.quantile_value <= (hq_q[15:0] == '0) ? qa_q
                                                    : qa_q + prod[SampleW+15:16];
      result_q.sample_count   <= count_q;
      result_q.overflow_flag  <= drop_q;
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

endmodule
`default_nettype wire
